// ===== rtl/pwbc_pkg.sv =====
// pwbc_pkg: shared types and constants for the pid controller with bias and clamp
// no dependencies

package pwbc_pkg;

  // fixed field widths
  localparam int GAIN_WIDTH      = 32;
  localparam int BIAS_WIDTH      = 8;
  localparam int DRIVE_WIDTH     = 9;
  localparam int DRIVE_LIMIT     = 255;
  localparam int CFG_INDEX_WIDTH = 2;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP   = 2'd0,
    REG_KI   = 2'd1,
    REG_KD   = 2'd2,
    REG_BIAS = 2'd3
  } cfg_reg_t;

  typedef logic signed [GAIN_WIDTH-1:0] gain_t;

  // gain set handed to the multiply stage
  typedef struct packed {
    gain_t kp;
    gain_t ki;
    gain_t kd;
  } gains_t;

endpackage

// ===== rtl/pid_with_bias_and_clamp.sv =====
// pid_with_bias_and_clamp: top level, configuration registers and the pipeline
// depends on pwbc_pkg, pwbc_history, pwbc_mac, pwbc_shape

// Fixed-point pid controller. Each error word yields one drive word equal to
// kp*e + ki*sum + kd*delta (gains signed with GAIN_FRAC_BITS fraction bits),
// biased away from zero by bias_offset, clamped to +/-255 and truncated toward
// zero; clamped flags a result at the limit. The block takes one word per
// clock while back pressure allows; an accepted word loads the input stage,
// then passes the product stage, sum stage and output register, and back
// pressure on the output stalls the pipeline stage by stage. Any configuration
// write clears the running sum, previous error and primed flag, as does a word
// with restart set, before that word is used.
// Write configuration only while the pipeline is empty.

module pid_with_bias_and_clamp #(
  parameter int ERROR_WIDTH    = 16,
  parameter int GAIN_FRAC_BITS = 16,
  parameter int ACC_WIDTH      = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_write,
  input  logic [pwbc_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [pwbc_pkg::GAIN_WIDTH-1:0]          cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [ERROR_WIDTH-1:0]            error_sample,
  input  logic                                     restart,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [pwbc_pkg::DRIVE_WIDTH-1:0]  drive,
  output logic                                     clamped
);
  import pwbc_pkg::*;

  localparam int PA_WIDTH  = GAIN_WIDTH + ACC_WIDTH;
  localparam int PD_WIDTH  = GAIN_WIDTH + ERROR_WIDTH + 1;
  localparam int SUM_WIDTH = ((PA_WIDTH > PD_WIDTH) ? PA_WIDTH : PD_WIDTH) + 2;

  gains_t                        gains;
  logic [BIAS_WIDTH-1:0]         bias_offset;

  logic                          s_valid;
  logic                          s_ready;
  logic signed [ERROR_WIDTH-1:0] s_error;
  logic signed [ACC_WIDTH-1:0]   s_acc;
  logic signed [ERROR_WIDTH:0]   s_delta;
  logic                          t_valid;
  logic                          t_ready;
  logic signed [SUM_WIDTH-1:0]   t_sum;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains       <= '0;
      bias_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_KP:   gains.kp    <= cfg_data;
        REG_KI:   gains.ki    <= cfg_data;
        REG_KD:   gains.kd    <= cfg_data;
        REG_BIAS: bias_offset <= cfg_data[BIAS_WIDTH-1:0];
        default:  ;
      endcase
    end
  end

  // history and input stage
  pwbc_history #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_history (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_write),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .error_sample (error_sample),
    .restart      (restart),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_error      (s_error),
    .s_acc        (s_acc),
    .s_delta      (s_delta)
  );

  // products and sum
  pwbc_mac #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .gains   (gains),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_error (s_error),
    .s_acc   (s_acc),
    .s_delta (s_delta),
    .t_valid (t_valid),
    .t_ready (t_ready),
    .t_sum   (t_sum)
  );

  // bias, clamp and output register
  pwbc_shape #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_shape (
    .clk         (clk),
    .rst         (rst),
    .bias_offset (bias_offset),
    .t_valid     (t_valid),
    .t_ready     (t_ready),
    .t_sum       (t_sum),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .clamped     (clamped)
  );

  // a flagged result sits exactly at the limit
  a_clamp_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamped |->
      (drive == DRIVE_WIDTH'(DRIVE_LIMIT)) || (drive == -DRIVE_WIDTH'(DRIVE_LIMIT)))
    else $error("clamped result not at the limit");

  // an unflagged result stays strictly inside the limit
  a_inside_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !clamped |->
      (drive > -DRIVE_WIDTH'(DRIVE_LIMIT)) && (drive < DRIVE_WIDTH'(DRIVE_LIMIT)))
    else $error("unclamped result reached the limit");

  // an empty output register lets the whole pipeline move
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a taken result is replaced or the output goes idle only after a handshake
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped without handshake");

endmodule

// ===== rtl/pwbc_history.sv =====
// pwbc_history: error history (saturating sum, previous error, primed flag)
// and the input stage register holding error, sum and delta
// depends on pwbc_pkg

module pwbc_history #(
  parameter int ERROR_WIDTH = 16,
  parameter int ACC_WIDTH   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ERROR_WIDTH-1:0] error_sample,
  input  logic                          restart,
  output logic                          s_valid,
  input  logic                          s_ready,
  output logic signed [ERROR_WIDTH-1:0] s_error,
  output logic signed [ACC_WIDTH-1:0]   s_acc,
  output logic signed [ERROR_WIDTH:0]   s_delta
);
  import pwbc_pkg::*;

  localparam int SUM_WIDTH = ((ACC_WIDTH > ERROR_WIDTH) ? ACC_WIDTH : ERROR_WIDTH) + 1;
  localparam logic signed [SUM_WIDTH-1:0] ACC_MAX =
    {{(SUM_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] ACC_MIN = ~ACC_MAX;

  logic signed [ACC_WIDTH-1:0]   acc;
  logic signed [ERROR_WIDTH-1:0] prev_error;
  logic                          primed;

  logic signed [ACC_WIDTH-1:0]   acc_base;
  logic signed [ERROR_WIDTH-1:0] prev_base;
  logic                          primed_base;
  logic signed [SUM_WIDTH-1:0]   acc_ext;
  logic signed [SUM_WIDTH-1:0]   err_ext;
  logic signed [SUM_WIDTH-1:0]   sum;
  logic signed [ACC_WIDTH-1:0]   acc_next;
  logic signed [ERROR_WIDTH:0]   err_wide;
  logic signed [ERROR_WIDTH:0]   prev_wide;
  logic signed [ERROR_WIDTH:0]   delta_next;
  logic                          accept;

  assign in_ready = !s_valid || s_ready;
  assign accept   = in_valid && in_ready;

  // restart drops the history ahead of this word
  always_comb begin
    acc_base    = restart ? '0 : acc;
    prev_base   = restart ? '0 : prev_error;
    primed_base = restart ? 1'b0 : primed;
  end

  // saturating running sum
  always_comb begin
    acc_ext = SUM_WIDTH'(acc_base);
    err_ext = SUM_WIDTH'(error_sample);
    sum     = acc_ext + err_ext;
    if (sum > ACC_MAX) begin
      acc_next = ACC_MAX[ACC_WIDTH-1:0];
    end else if (sum < ACC_MIN) begin
      acc_next = ACC_MIN[ACC_WIDTH-1:0];
    end else begin
      acc_next = sum[ACC_WIDTH-1:0];
    end
  end

  // difference term, zero on the first word after a clear
  always_comb begin
    err_wide   = (ERROR_WIDTH+1)'(error_sample);
    prev_wide  = (ERROR_WIDTH+1)'(prev_base);
    delta_next = primed_base ? (err_wide - prev_wide) : '0;
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      prev_error <= '0;
      primed     <= 1'b0;
    end else if (clear) begin
      acc        <= '0;
      prev_error <= '0;
      primed     <= 1'b0;
    end else if (accept) begin
      acc        <= acc_next;
      prev_error <= error_sample;
      primed     <= 1'b1;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s_error <= error_sample;
      s_acc   <= acc_next;
      s_delta <= delta_next;
    end
  end

endmodule

// ===== rtl/pwbc_mac.sv =====
// pwbc_mac: three gain products in one stage, their exact sum in the next
// depends on pwbc_pkg

module pwbc_mac #(
  parameter int ERROR_WIDTH = 16,
  parameter int ACC_WIDTH   = 32,
  parameter int SUM_WIDTH   = 66
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pwbc_pkg::gains_t              gains,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  logic signed [ERROR_WIDTH-1:0] s_error,
  input  logic signed [ACC_WIDTH-1:0]   s_acc,
  input  logic signed [ERROR_WIDTH:0]   s_delta,
  output logic                          t_valid,
  input  logic                          t_ready,
  output logic signed [SUM_WIDTH-1:0]   t_sum
);
  import pwbc_pkg::*;

  localparam int PE_WIDTH = GAIN_WIDTH + ERROR_WIDTH;
  localparam int PA_WIDTH = GAIN_WIDTH + ACC_WIDTH;
  localparam int PD_WIDTH = GAIN_WIDTH + ERROR_WIDTH + 1;

  gain_t                      kp;
  gain_t                      ki;
  gain_t                      kd;
  logic                       p_valid;
  logic                       p_ready;
  logic signed [PE_WIDTH-1:0] prod_e;
  logic signed [PA_WIDTH-1:0] prod_a;
  logic signed [PD_WIDTH-1:0] prod_d;
  logic signed [SUM_WIDTH-1:0] ext_e;
  logic signed [SUM_WIDTH-1:0] ext_a;
  logic signed [SUM_WIDTH-1:0] ext_d;

  assign kp      = gains.kp;
  assign ki      = gains.ki;
  assign kd      = gains.kd;
  assign p_ready = !t_valid || t_ready;
  assign s_ready = !p_valid || p_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (s_ready) begin
      p_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      prod_e <= PE_WIDTH'(kp) * PE_WIDTH'(s_error);
      prod_a <= PA_WIDTH'(ki) * PA_WIDTH'(s_acc);
      prod_d <= PD_WIDTH'(kd) * PD_WIDTH'(s_delta);
    end
  end

  // sum stage
  always_comb begin
    ext_e = SUM_WIDTH'(prod_e);
    ext_a = SUM_WIDTH'(prod_a);
    ext_d = SUM_WIDTH'(prod_d);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t_valid <= 1'b0;
    end else if (p_ready) begin
      t_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && p_valid) begin
      t_sum <= ext_e + ext_a + ext_d;
    end
  end

endmodule

// ===== rtl/pwbc_shape.sv =====
// pwbc_shape: bias away from zero, clamp to the drive limit, truncate toward zero,
// and the output register
// depends on pwbc_pkg

module pwbc_shape #(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int SUM_WIDTH      = 66
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [pwbc_pkg::BIAS_WIDTH-1:0]      bias_offset,
  input  logic                                 t_valid,
  output logic                                 t_ready,
  input  logic signed [SUM_WIDTH-1:0]          t_sum,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pwbc_pkg::DRIVE_WIDTH-1:0] drive,
  output logic                                 clamped
);
  import pwbc_pkg::*;

  localparam int TW = SUM_WIDTH + 1;
  localparam logic signed [TW-1:0] LIM =
    TW'(longint'(DRIVE_LIMIT) << GAIN_FRAC_BITS);
  localparam logic signed [DRIVE_WIDTH-1:0] DRIVE_MAX = DRIVE_WIDTH'(DRIVE_LIMIT);

  logic signed [TW-1:0]            t_ext;
  logic signed [TW-1:0]            bias_scaled;
  logic signed [TW-1:0]            t_bias;
  logic signed [TW-1:0]            mag;
  logic [BIAS_WIDTH-1:0]           quot;
  logic signed [DRIVE_WIDTH-1:0]   quot_ext;
  logic signed [DRIVE_WIDTH-1:0]   drive_next;
  logic                            clamped_next;

  assign t_ready = !out_valid || out_ready;

  // bias away from zero, exact zero stays zero
  always_comb begin
    t_ext       = TW'(t_sum);
    bias_scaled = TW'({bias_offset, {GAIN_FRAC_BITS{1'b0}}});
    if (t_ext > 0) begin
      t_bias = t_ext + bias_scaled;
    end else if (t_ext < 0) begin
      t_bias = t_ext - bias_scaled;
    end else begin
      t_bias = '0;
    end
  end

  // clamp, then drop the fraction toward zero
  always_comb begin
    mag      = t_bias[TW-1] ? -t_bias : t_bias;
    quot     = mag[GAIN_FRAC_BITS +: BIAS_WIDTH];
    quot_ext = DRIVE_WIDTH'(quot);
    if (t_bias >= LIM) begin
      drive_next   = DRIVE_MAX;
      clamped_next = 1'b1;
    end else if (t_bias <= -LIM) begin
      drive_next   = -DRIVE_MAX;
      clamped_next = 1'b1;
    end else begin
      drive_next   = t_bias[TW-1] ? -quot_ext : quot_ext;
      clamped_next = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (t_ready) begin
      out_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (t_ready && t_valid) begin
      drive   <= drive_next;
      clamped <= clamped_next;
    end
  end

endmodule

// ===== verif/pid_with_bias_and_clamp_tb.sv =====
// pid_with_bias_and_clamp_tb: self-checking testbench for the biased, clamped pid controller
// depends on pwbc_pkg and pid_with_bias_and_clamp; drives error words and checks each drive word
// against a bit-exact predictor, with random idling on both handshakes

module pid_with_bias_and_clamp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwbc_pkg::*;

  localparam int ERR_W       = 16;
  localparam int FRAC        = 16;
  localparam int ACC_W       = 32;
  localparam int WIDE        = 96;
  localparam int SETTLE      = 10;
  localparam int MAX_CYCLES  = 100000;
  localparam int MAX_REPORTS = 20;
  localparam int RUN_WORDS   = 64;

  typedef struct packed {
    logic signed [DRIVE_WIDTH-1:0] drive;
    logic                          clamped;
  } drive_word_t;

  // dut connections, inputs known from time zero
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  cfg_reg_t                      cfg_index = REG_KP;
  logic [GAIN_WIDTH-1:0]         cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [ERR_W-1:0]       error_sample = '0;
  logic                          restart = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [DRIVE_WIDTH-1:0] drive;
  logic                          clamped;

  // predictor copy of configuration and history
  logic signed [GAIN_WIDTH-1:0] kp_gain = '0;
  logic signed [GAIN_WIDTH-1:0] ki_gain = '0;
  logic signed [GAIN_WIDTH-1:0] kd_gain = '0;
  logic [BIAS_WIDTH-1:0]        bias_level = '0;
  logic signed [ACC_W-1:0]      err_sum = '0;
  logic signed [ERR_W-1:0]      last_err = '0;
  logic                         primed = 1'b0;

  drive_word_t drive_expect_q[$];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int error_count   = 0;
  int words_checked = 0;
  int cfg_writes    = 0;
  int sat_hits      = 0;
  int clamp_hits    = 0;
  int restarts      = 0;
  int extreme_sets  = 0;

  pid_with_bias_and_clamp #(
    .ERROR_WIDTH   (ERR_W),
    .GAIN_FRAC_BITS(FRAC),
    .ACC_WIDTH     (ACC_W)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .error_sample(error_sample),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .clamped     (clamped)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d drive words still pending", cycle_count,
               drive_expect_q.size());
      $display("pid_with_bias_and_clamp_tb: done, errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // exact pid step: updates history, returns the expected drive word
  function automatic drive_word_t pid_predict(input logic signed [ERR_W-1:0] e,
                                              input logic rs);
    logic signed [ERR_W:0]  e_x;
    logic signed [ERR_W:0]  prev_x;
    logic signed [ERR_W:0]  delta;
    logic signed [ACC_W:0]  sum_x;
    logic signed [WIDE-1:0] total;
    logic signed [WIDE-1:0] lim_w;
    logic signed [WIDE-1:0] bias_w;
    logic signed [WIDE-1:0] mag;
    logic signed [WIDE-1:0] kp_w, ki_w, kd_w, e_w, s_w, d_w;
    drive_word_t res;
    if (rs) begin
      err_sum  = '0;
      last_err = '0;
      primed   = 1'b0;
    end
    e_x    = (ERR_W+1)'(e);
    prev_x = (ERR_W+1)'(last_err);
    if (primed) delta = e_x - prev_x;
    else delta = '0;
    // saturating running sum
    sum_x = (ACC_W+1)'(err_sum);
    sum_x = sum_x + e_x;
    if (sum_x[ACC_W] != sum_x[ACC_W-1]) begin
      err_sum = sum_x[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      sat_hits++;
    end else begin
      err_sum = sum_x[ACC_W-1:0];
    end
    last_err = e;
    primed   = 1'b1;
    // weighted sum without wrap
    kp_w  = WIDE'(kp_gain);
    ki_w  = WIDE'(ki_gain);
    kd_w  = WIDE'(kd_gain);
    e_w   = WIDE'(e);
    s_w   = WIDE'(err_sum);
    d_w   = WIDE'(delta);
    total = kp_w * e_w + ki_w * s_w + kd_w * d_w;
    // bias away from zero
    bias_w = WIDE'(bias_level);
    bias_w = bias_w <<< FRAC;
    if (total > 0) total = total + bias_w;
    else if (total < 0) total = total - bias_w;
    // clamp, then truncate toward zero
    lim_w = WIDE'(DRIVE_LIMIT);
    lim_w = lim_w <<< FRAC;
    res.clamped = 1'b0;
    if (total >= lim_w) begin
      res.drive   = DRIVE_WIDTH'(DRIVE_LIMIT);
      res.clamped = 1'b1;
    end else if (total <= -lim_w) begin
      res.drive   = -DRIVE_WIDTH'(DRIVE_LIMIT);
      res.clamped = 1'b1;
    end else if (total >= 0) begin
      mag       = total >>> FRAC;
      res.drive = mag[DRIVE_WIDTH-1:0];
    end else begin
      mag       = (-total) >>> FRAC;
      mag       = -mag;
      res.drive = mag[DRIVE_WIDTH-1:0];
    end
    if (res.clamped) clamp_hits++;
    return res;
  endfunction

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // compare each accepted drive word with the oldest expectation
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expect_q.size() == 0) begin
        report_mismatch($sformatf("drive word %0d / clamped %0b with nothing pending",
                                  drive, clamped));
      end else begin
        want = drive_expect_q.pop_front();
        words_checked++;
        if (drive !== want.drive)
          report_mismatch($sformatf("word %0d: drive %0d, want %0d", words_checked, drive,
                                    want.drive));
        if (clamped !== want.clamped)
          report_mismatch($sformatf("word %0d: clamped %0b, want %0b", words_checked,
                                    clamped, want.clamped));
      end
    end
  end

  // offer one error word, hold it until accepted, then maybe idle
  task automatic send_error(input logic signed [ERR_W-1:0] e, input logic rs);
    int gap;
    in_valid     <= 1'b1;
    error_sample <= e;
    restart      <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    drive_expect_q.push_back(pid_predict(e, rs));
    if (rs) restarts++;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid     <= 1'b0;
      error_sample <= ERR_W'($urandom);
      restart      <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, let every pending word drain, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write all four registers while idle; every write clears the history
  task automatic load_gains(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                            input logic [7:0] b);
    logic [31:0] vals [4];
    vals[0] = p;
    vals[1] = i;
    vals[2] = d;
    vals[3] = {24'($urandom_range(0, 32'h00FF_FFFF)), b};
    wait_idle();
    for (int r = 0; r < 4; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_data  <= vals[r];
      @(posedge clk);
      case (cfg_reg_t'(r))
        REG_KP:   kp_gain = vals[r];
        REG_KI:   ki_gain = vals[r];
        REG_KD:   kd_gain = vals[r];
        REG_BIAS: bias_level = vals[r][7:0];
        default:  ;
      endcase
      err_sum  = '0;
      last_err = '0;
      primed   = 1'b0;
      cfg_writes++;
    end
    cfg_write <= 1'b0;
    cfg_data  <= $urandom;
  endtask

  // gain around zero: mostly within +/-2^span, sometimes an extreme or any value
  function automatic logic [31:0] rand_gain(input int span);
    int v;
    case ($urandom_range(9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = 0;
      3:       v = $urandom;
      default: v = int'($urandom_range(0, 1 << (span + 1))) - (1 << span);
    endcase
    return v;
  endfunction

  function automatic logic signed [ERR_W-1:0] rand_error();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 800)) - 400;
      5, 6, 7:       v = $urandom;
      8:             v = $urandom_range(1) ? 32767 : -32768;
      default:       v = 0;
    endcase
    return ERR_W'(v);
  endfunction

  // zero gains after reset give zero drive whatever the error
  task automatic test_reset_state();
    send_error(16'sd32767, 1'b0);
    send_error(-16'sd32768, 1'b1);
    send_error(16'sd0, 1'b0);
  endtask

  // limits, bias, truncation, first-sample derivative, extreme gains
  task automatic test_directed_cases();
    load_gains(32'h0001_0000, 32'h0, 32'h0, 8'd0);
    send_error(16'sd255, 1'b0);
    send_error(16'sd254, 1'b0);
    send_error(-16'sd255, 1'b0);
    send_error(-16'sd256, 1'b0);
    send_error(16'sd32767, 1'b0);
    send_error(-16'sd32768, 1'b0);
    load_gains(32'h0000_8000, 32'h0, 32'h0, 8'd7);
    send_error(16'sd0, 1'b0);
    send_error(16'sd3, 1'b0);
    send_error(-16'sd3, 1'b0);
    send_error(16'sd1, 1'b0);
    load_gains(32'h0, 32'h0, 32'h0001_0000, 8'd0);
    send_error(16'sd100, 1'b0);
    send_error(16'sd150, 1'b0);
    send_error(16'sd150, 1'b1);
    send_error(-16'sd100, 1'b0);
    load_gains(32'h0, 32'h0001_0000, 32'h0, 8'd255);
    send_error(16'sd1, 1'b0);
    send_error(-16'sd1, 1'b0);
    send_error(-16'sd1, 1'b0);
    load_gains(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    send_error(16'sd32767, 1'b0);
    send_error(-16'sd32768, 1'b0);
  endtask

  // run the sum a long way up and then down at full-scale error; the
  // proportional term opposes and outweighs the sum, so the drive stays clamped
  task automatic test_sum_runs();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    load_gains(32'hFFFE_FFFE, 32'h0000_0001, 32'h0, 8'd0);
    repeat (RUN_WORDS) send_error(16'sd32767, 1'b0);
    load_gains(32'hFFFF_0000, 32'h0000_0001, 32'h0, 8'd0);
    repeat (RUN_WORDS) send_error(-16'sd32768, 1'b0);
  endtask

  // long receiver hold-off while words keep coming, so the input stalls
  task automatic test_back_pressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    load_gains(rand_gain(18), rand_gain(12), rand_gain(16), 8'($urandom_range(0, 255)));
    hold_left <= 200;
    repeat (40) send_error(rand_error(), ($urandom_range(99) < 4));
  endtask

  // random configurations and error streams under one idling pattern
  task automatic test_random_phase(input int idle_pct, input int stall_pct);
    logic [7:0] b;
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int k = 0; k < 4; k++) begin
      if (k == 0) begin
        // extreme settings, alternating between phases
        if (extreme_sets % 2 == 0)
          load_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255);
        else
          load_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0);
        extreme_sets++;
      end else begin
        b = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
        load_gains(rand_gain(18), rand_gain(12), rand_gain(16), b);
      end
      repeat (60) send_error(rand_error(), ($urandom_range(99) < 4));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_cases();
    test_sum_runs();
    test_back_pressure();
    test_random_phase(0, 0);
    test_random_phase(75, 0);
    test_random_phase(0, 75);
    test_random_phase(25, 25);
    wait_idle();
    $display("checked %0d drive words (%0d clamped, %0d with a saturated sum, %0d restarts)",
             words_checked, clamp_hits, sat_hits, restarts);
    $display("%0d register writes over %0d extreme settings, %0d mismatches, %0d cycles",
             cfg_writes, extreme_sets, error_count, cycle_count);
    if (error_count == 0) begin
      $display("pid_with_bias_and_clamp_tb: done, clean");
    end else begin
      $display("pid_with_bias_and_clamp_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pwbc_pkg.sv
rtl/pwbc_history.sv
rtl/pwbc_mac.sv
rtl/pwbc_shape.sv
rtl/pid_with_bias_and_clamp.sv
verif/pid_with_bias_and_clamp_tb.sv
